/* sv/fsp_pkg.sv */
package fsp_pkg;

   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_SPEC    = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;
   localparam logic [1:0] KIND_EMPTY   = 2'd3;

   localparam logic [2:0] LM_NONE = 3'd0;
   localparam logic [2:0] LM_HH   = 3'd1;
   localparam logic [2:0] LM_H    = 3'd2;
   localparam logic [2:0] LM_L    = 3'd3;
   localparam logic [2:0] LM_LL   = 3'd4;
   localparam logic [2:0] LM_BIGL = 3'd5;

   localparam logic [3:0] TYPE_C       = 4'd0;
   localparam logic [3:0] TYPE_S       = 4'd1;
   localparam logic [3:0] TYPE_P       = 4'd2;
   localparam logic [3:0] TYPE_D       = 4'd3;
   localparam logic [3:0] TYPE_U       = 4'd4;
   localparam logic [3:0] TYPE_O       = 4'd5;
   localparam logic [3:0] TYPE_X_LOW   = 4'd6;
   localparam logic [3:0] TYPE_X_UP    = 4'd7;
   localparam logic [3:0] CONV_PERCENT = 4'd8;
   localparam logic [3:0] TYPE_F       = 4'd9;
   localparam logic [3:0] TYPE_I       = 4'd10;
   localparam logic [3:0] CONV_NONE    = 4'd11;

   localparam logic [7:0] CH_H_LOW = 8'h68;
   localparam logic [7:0] CH_L_LOW = 8'h6C;
   localparam logic [7:0] CH_L_UP  = 8'h4C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_X_LOW = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_I     = 8'h69;

   function automatic logic [3:0] letter_type(input logic [7:0] c);
      case (c)
         CH_C:     return TYPE_C;
         CH_S:     return TYPE_S;
         CH_P:     return TYPE_P;
         CH_D:     return TYPE_D;
         CH_U:     return TYPE_U;
         CH_O:     return TYPE_O;
         CH_X_LOW: return TYPE_X_LOW;
         CH_X_UP:  return TYPE_X_UP;
         CH_PCT:   return CONV_PERCENT;
         CH_F:     return TYPE_F;
         CH_I:     return TYPE_I;
         default:  return CONV_NONE;
      endcase
   endfunction

   function automatic logic [4:0] flag_bit(input logic [7:0] c);
      case (c)
         CH_MINUS: return 5'b00001;
         CH_SHARP: return 5'b00010;
         CH_PLUS:  return 5'b00100;
         CH_ZERO:  return 5'b01000;
         CH_SPACE: return 5'b10000;
         default:  return 5'b00000;
      endcase
   endfunction

endpackage

/* sv/fsp_parse.sv */
module fsp_parse
   import fsp_pkg::*;
#(
   parameter int NUMBER_BITS = 16,
   parameter int COUNT_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_char,
   input  logic                   queue_full,
   output logic                   push,
   output logic                   push_literal,
   output logic [7:0]             push_byte,
   output logic [4:0]             push_flags,
   output logic [NUMBER_BITS-1:0] push_width,
   output logic                   push_width_given,
   output logic [NUMBER_BITS-1:0] push_prec,
   output logic                   push_prec_given,
   output logic [2:0]             push_length,
   output logic [COUNT_BITS-1:0]  push_count
);

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_FLAGS = 7'b0000010,
      PH_WIDTH = 7'b0000100,
      PH_PREC  = 7'b0001000,
      PH_LEN_H = 7'b0010000,
      PH_LEN_L = 7'b0100000,
      PH_TYPE  = 7'b1000000
   } phase_type;

   localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

   function automatic logic [NUMBER_BITS-1:0] acc_digit(
      input logic [NUMBER_BITS-1:0] acc,
      input logic [3:0]             d
   );
      logic [NUMBER_BITS+3:0] v;
      v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{NUMBER_BITS{1'b0}}, d};
      if (v[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
         return NUM_MAX;
      end
      return v[NUMBER_BITS-1:0];
   endfunction

   phase_type              phase_ff, phase_in;
   logic [4:0]             flags_ff, flags_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic                   wseen_ff, wseen_in;
   logic [NUMBER_BITS-1:0] prec_ff, prec_in;
   logic                   dot_ff, dot_in;
   logic [2:0]             len_ff, len_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   accept;
   logic                   digit;
   logic [4:0]             flag;
   logic [NUMBER_BITS-1:0] width_step;
   logic [NUMBER_BITS-1:0] prec_step;
   logic [COUNT_BITS-1:0]  count_next;
   logic                   tail;
   logic                   dot_ok;
   logic                   finish;

   assign accept     = in_valid && !queue_full;
   assign digit      = in_char inside {[CH_ZERO:CH_NINE]};
   assign flag       = flag_bit(in_char);
   assign width_step = acc_digit((phase_ff == PH_WIDTH) ? width_ff : '0, in_char[3:0]);
   assign prec_step  = acc_digit(prec_ff, in_char[3:0]);
   assign count_next = (count_ff == CNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);

   always_comb begin
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      width_in     = width_ff;
      wseen_in     = wseen_ff;
      prec_in      = prec_ff;
      dot_in       = dot_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      push         = 1'b0;
      push_literal = 1'b0;
      tail         = 1'b0;
      dot_ok       = 1'b0;
      finish       = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (in_char == CH_PCT) begin
                  phase_in = PH_FLAGS;
                  flags_in = '0;
                  width_in = '0;
                  wseen_in = 1'b0;
                  prec_in  = '0;
                  dot_in   = 1'b0;
                  len_in   = LM_NONE;
                  count_in = '0;
               end else begin
                  push         = 1'b1;
                  push_literal = 1'b1;
               end
            end
            PH_FLAGS: begin
               if (flag != 5'd0) begin
                  flags_in = flags_ff | flag;
                  count_in = count_next;
               end else if (digit) begin
                  width_in = width_step;
                  wseen_in = 1'b1;
                  phase_in = PH_WIDTH;
                  count_in = count_next;
               end else begin
                  tail   = 1'b1;
                  dot_ok = 1'b1;
               end
            end
            PH_WIDTH: begin
               if (digit) begin
                  width_in = width_step;
                  count_in = count_next;
               end else begin
                  tail   = 1'b1;
                  dot_ok = 1'b1;
               end
            end
            PH_PREC: begin
               if (digit) begin
                  prec_in  = prec_step;
                  count_in = count_next;
               end else begin
                  tail = 1'b1;
               end
            end
            PH_LEN_H: begin
               if (in_char == CH_H_LOW) begin
                  len_in   = LM_HH;
                  phase_in = PH_TYPE;
                  count_in = count_next;
               end else begin
                  finish = 1'b1;
               end
            end
            PH_LEN_L: begin
               if (in_char == CH_L_LOW) begin
                  len_in   = LM_LL;
                  phase_in = PH_TYPE;
                  count_in = count_next;
               end else begin
                  finish = 1'b1;
               end
            end
            PH_TYPE: begin
               finish = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (tail) begin
            if (dot_ok && in_char == CH_DOT) begin
               dot_in   = 1'b1;
               prec_in  = '0;
               phase_in = PH_PREC;
               count_in = count_next;
            end else if (in_char == CH_H_LOW) begin
               len_in   = LM_H;
               phase_in = PH_LEN_H;
               count_in = count_next;
            end else if (in_char == CH_L_LOW) begin
               len_in   = LM_L;
               phase_in = PH_LEN_L;
               count_in = count_next;
            end else if (in_char == CH_L_UP) begin
               len_in   = LM_BIGL;
               phase_in = PH_TYPE;
               count_in = count_next;
            end else begin
               finish = 1'b1;
            end
         end
         if (finish) begin
            push     = 1'b1;
            phase_in = PH_IDLE;
            flags_in = '0;
            width_in = '0;
            wseen_in = 1'b0;
            prec_in  = '0;
            dot_in   = 1'b0;
            len_in   = LM_NONE;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flags_ff <= '0;
         width_ff <= '0;
         wseen_ff <= 1'b0;
         prec_ff  <= '0;
         dot_ff   <= 1'b0;
         len_ff   <= LM_NONE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         width_ff <= width_in;
         wseen_ff <= wseen_in;
         prec_ff  <= prec_in;
         dot_ff   <= dot_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   assign push_byte        = in_char;
   assign push_flags       = flags_ff;
   assign push_width       = width_ff;
   assign push_width_given = wseen_ff;
   assign push_prec        = prec_ff;
   assign push_prec_given  = dot_ff;
   assign push_length      = len_ff;
   assign push_count       = count_ff;

   assert property (@(posedge clock) disable iff (reset)
      (push && !push_literal) |=> (phase_ff == PH_IDLE && count_ff == '0))
   else $error("spec record did not return parser to idle");

endmodule

/* sv/fsp_queue.sv */
module fsp_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in;
   logic [PTR_BITS-1:0]  rd_ff, rd_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   assert property (@(posedge clock) disable iff (reset) !(push && full))
   else $error("word pushed into full queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && !pop_valid))
   else $error("word popped from empty queue");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_BITS'(DEPTH))
   else $error("queue fill count beyond depth");

endmodule

/* sv/fsp_emit.sv */
module fsp_emit
   import fsp_pkg::*;
#(
   parameter int NUMBER_BITS = 16,
   parameter int COUNT_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  logic                   q_literal,
   input  logic [7:0]             q_byte,
   input  logic [4:0]             q_flags,
   input  logic [NUMBER_BITS-1:0] q_width,
   input  logic                   q_width_given,
   input  logic [NUMBER_BITS-1:0] q_prec,
   input  logic                   q_prec_given,
   input  logic [2:0]             q_length,
   input  logic [COUNT_BITS-1:0]  q_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_byte_out,
   output logic [4:0]             rsp_flag_bits,
   output logic [NUMBER_BITS-1:0] rsp_width_value,
   output logic                   rsp_width_given,
   output logic [NUMBER_BITS-1:0] rsp_precision_value,
   output logic                   rsp_precision_given,
   output logic [2:0]             rsp_length_mod,
   output logic [3:0]             rsp_conv_type,
   output logic [COUNT_BITS-1:0]  rsp_spec_length
);

   logic                   valid_ff, valid_in;
   logic [1:0]             kind_ff;
   logic [7:0]             byte_ff;
   logic [4:0]             flags_ff;
   logic [NUMBER_BITS-1:0] width_ff;
   logic                   wgiven_ff;
   logic [NUMBER_BITS-1:0] prec_ff;
   logic                   pgiven_ff;
   logic [2:0]             len_ff;
   logic [3:0]             conv_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   logic [3:0] conv;
   logic [1:0] kind;

   assign q_pop = q_valid && (!valid_ff || !rsp_stall);
   assign conv  = q_literal ? CONV_NONE : letter_type(q_byte);

   always_comb begin
      if (q_literal) begin
         kind = KIND_LITERAL;
      end else if (conv != CONV_NONE) begin
         kind = KIND_SPEC;
      end else if (q_count != '0) begin
         kind = KIND_INVALID;
      end else begin
         kind = KIND_EMPTY;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= kind;
         byte_ff   <= q_byte;
         flags_ff  <= q_literal ? 5'd0 : q_flags;
         width_ff  <= q_literal ? '0 : q_width;
         wgiven_ff <= q_literal ? 1'b0 : q_width_given;
         prec_ff   <= q_literal ? '0 : q_prec;
         pgiven_ff <= q_literal ? 1'b0 : q_prec_given;
         len_ff    <= q_literal ? LM_NONE : q_length;
         conv_ff   <= conv;
         count_ff  <= q_literal ? '0 : q_count;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_byte_out        = byte_ff;
   assign rsp_flag_bits       = flags_ff;
   assign rsp_width_value     = width_ff;
   assign rsp_width_given     = wgiven_ff;
   assign rsp_precision_value = prec_ff;
   assign rsp_precision_given = pgiven_ff;
   assign rsp_length_mod      = len_ff;
   assign rsp_conv_type       = conv_ff;
   assign rsp_spec_length     = count_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_LITERAL) |->
         (rsp_conv_type == CONV_NONE && rsp_spec_length == '0 && rsp_flag_bits == 5'd0))
   else $error("literal word carries spec fields");

endmodule

/* sv/printf_format_spec_parser_unit.sv */
// Format string spec parser. Feed one byte of a format string per req_ word on
// req_char_in. Plain bytes come back as literal words; a '%' opens a spec that
// is gathered (flags, width, precision, length) and closed by the next byte
// that is not part of it, which yields one spec, invalid-spec or empty-spec
// word carrying the gathered fields. The opening '%' and every byte inside a
// spec yield nothing.
// Throughput: one byte per cycle while req_stall is low, set by the update of the
// parse state (one multiply-by-ten and saturate step per digit).
// A result word is written into the queue on the edge that accepts the byte
// that finishes it, and moves on into the output register once that register
// is free. A two-word queue sits between the parser and the output register,
// so input keeps flowing while a finished word waits.
// When rsp_stall holds, the output word stays put; once the queue fills,
// req_stall rises and input halts without losing any byte.
// Reset (synchronous) returns the parser to outside-a-spec, empties the queue
// and drops any pending output word; no clearing pass is needed.
module printf_format_spec_parser_unit
   import fsp_pkg::*;
#(
   parameter int NUMBER_BITS = 16,
   parameter int COUNT_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_byte_out,
   output logic [4:0]             rsp_flag_bits,
   output logic [NUMBER_BITS-1:0] rsp_width_value,
   output logic                   rsp_width_given,
   output logic [NUMBER_BITS-1:0] rsp_precision_value,
   output logic                   rsp_precision_given,
   output logic [2:0]             rsp_length_mod,
   output logic [3:0]             rsp_conv_type,
   output logic [COUNT_BITS-1:0]  rsp_spec_length
);

   localparam int ENTRY_BITS = 19 + 2 * NUMBER_BITS + COUNT_BITS;
   localparam int QUEUE_DEPTH = 2;

   logic                   q_full;
   logic                   push;
   logic                   push_literal;
   logic [7:0]             push_byte;
   logic [4:0]             push_flags;
   logic [NUMBER_BITS-1:0] push_width;
   logic                   push_width_given;
   logic [NUMBER_BITS-1:0] push_prec;
   logic                   push_prec_given;
   logic [2:0]             push_length;
   logic [COUNT_BITS-1:0]  push_count;
   logic [ENTRY_BITS-1:0]  push_data;

   logic                   pop;
   logic                   pop_valid;
   logic [ENTRY_BITS-1:0]  pop_data;
   logic                   q_literal;
   logic [7:0]             q_byte;
   logic [4:0]             q_flags;
   logic [NUMBER_BITS-1:0] q_width;
   logic                   q_width_given;
   logic [NUMBER_BITS-1:0] q_prec;
   logic                   q_prec_given;
   logic [2:0]             q_length;
   logic [COUNT_BITS-1:0]  q_count;

   assign req_stall = q_full;

   fsp_parse #(
      .NUMBER_BITS (NUMBER_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_char          (req_char_in),
      .queue_full       (q_full),
      .push             (push),
      .push_literal     (push_literal),
      .push_byte        (push_byte),
      .push_flags       (push_flags),
      .push_width       (push_width),
      .push_width_given (push_width_given),
      .push_prec        (push_prec),
      .push_prec_given  (push_prec_given),
      .push_length      (push_length),
      .push_count       (push_count)
   );

   assign push_data = {push_literal, push_byte, push_flags, push_width, push_width_given,
                       push_prec, push_prec_given, push_length, push_count};

   fsp_queue #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   assign {q_literal, q_byte, q_flags, q_width, q_width_given,
           q_prec, q_prec_given, q_length, q_count} = pop_data;

   fsp_emit #(
      .NUMBER_BITS (NUMBER_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_emit (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (pop_valid),
      .q_pop               (pop),
      .q_literal           (q_literal),
      .q_byte              (q_byte),
      .q_flags             (q_flags),
      .q_width             (q_width),
      .q_width_given       (q_width_given),
      .q_prec              (q_prec),
      .q_prec_given        (q_prec_given),
      .q_length            (q_length),
      .q_count             (q_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_flag_bits       (rsp_flag_bits),
      .rsp_width_value     (rsp_width_value),
      .rsp_width_given     (rsp_width_given),
      .rsp_precision_value (rsp_precision_value),
      .rsp_precision_given (rsp_precision_given),
      .rsp_length_mod      (rsp_length_mod),
      .rsp_conv_type       (rsp_conv_type),
      .rsp_spec_length     (rsp_spec_length)
   );

endmodule

/* test/tb_top.sv */
module tb_top
   import fsp_pkg::*;
();

   localparam int NB = 16;
   localparam int CB = 8;
   localparam int unsigned NUM_MAX = (1 << NB) - 1;
   localparam int unsigned CNT_MAX = (1 << CB) - 1;
   localparam int RANDOM_BYTES = 800;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [6:0] {
      P_IDLE  = 7'b0000001,
      P_FLAGS = 7'b0000010,
      P_WIDTH = 7'b0000100,
      P_PREC  = 7'b0001000,
      P_LEN_H = 7'b0010000,
      P_LEN_L = 7'b0100000,
      P_TYPE  = 7'b1000000
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]    kind;
      logic [7:0]    byte_out;
      logic [4:0]    flags;
      logic [NB-1:0] width;
      logic          width_given;
      logic [NB-1:0] prec;
      logic          prec_given;
      logic [2:0]    len;
      logic [3:0]    conv;
      logic [CB-1:0] count;
   } spec_word_type;

   class spec_tracker_type;
      parse_phase_type phase;
      logic [4:0]      flags;
      logic [NB-1:0]   width_acc;
      logic            width_seen;
      logic [NB-1:0]   prec_acc;
      logic            dot_seen;
      logic [2:0]      len_seen;
      logic [CB-1:0]   count;
      spec_word_type   pending_words[$];
      int              errors;
      int              n_lit;
      int              n_spec;
      int              n_bad;
      int              n_empty;

      function new();
         phase = P_IDLE;
         clear();
         errors = 0;
         n_lit = 0;
         n_spec = 0;
         n_bad = 0;
         n_empty = 0;
      endfunction

      function void clear();
         flags = '0;
         width_acc = '0;
         width_seen = 1'b0;
         prec_acc = '0;
         dot_seen = 1'b0;
         len_seen = LM_NONE;
         count = '0;
      endfunction

      function logic [3:0] conv_code(logic [7:0] c);
         case (c)
            CH_C:     return TYPE_C;
            CH_S:     return TYPE_S;
            CH_P:     return TYPE_P;
            CH_D:     return TYPE_D;
            CH_U:     return TYPE_U;
            CH_O:     return TYPE_O;
            CH_X_LOW: return TYPE_X_LOW;
            CH_X_UP:  return TYPE_X_UP;
            CH_PCT:   return CONV_PERCENT;
            CH_F:     return TYPE_F;
            CH_I:     return TYPE_I;
            default:  return CONV_NONE;
         endcase
      endfunction

      function logic [4:0] flag_mask(logic [7:0] c);
         logic [4:0] m;
         m = '0;
         m[0] = (c == CH_MINUS);
         m[1] = (c == CH_SHARP);
         m[2] = (c == CH_PLUS);
         m[3] = (c == CH_ZERO);
         m[4] = (c == CH_SPACE);
         return m;
      endfunction

      function logic [NB-1:0] add_digit(logic [NB-1:0] acc, logic [7:0] c);
         int unsigned v;
         v = 32'(acc) * 10 + 32'(c - CH_ZERO);
         return (v > NUM_MAX) ? NB'(NUM_MAX) : NB'(v);
      endfunction

      function void bump();
         if (32'(count) < CNT_MAX) count++;
      endfunction

      function bit take_len(logic [7:0] c);
         if (c == CH_H_LOW) begin
            phase = P_LEN_H;
            len_seen = LM_H;
         end else if (c == CH_L_LOW) begin
            phase = P_LEN_L;
            len_seen = LM_L;
         end else if (c == CH_L_UP) begin
            phase = P_TYPE;
            len_seen = LM_BIGL;
         end else begin
            return 1'b0;
         end
         bump();
         return 1'b1;
      endfunction

      function void close(logic [7:0] c);
         spec_word_type w;
         w.conv = conv_code(c);
         if (w.conv != CONV_NONE) w.kind = KIND_SPEC;
         else if (count != 0) w.kind = KIND_INVALID;
         else w.kind = KIND_EMPTY;
         w.byte_out = c;
         w.flags = flags;
         w.width = width_acc;
         w.width_given = width_seen;
         w.prec = prec_acc;
         w.prec_given = dot_seen;
         w.len = len_seen;
         w.count = count;
         pending_words.push_back(w);
         phase = P_IDLE;
         clear();
      endfunction

      function void take_byte(logic [7:0] c);
         bit digit;
         spec_word_type w;
         digit = (c >= CH_ZERO) && (c <= CH_NINE);
         case (phase)
            P_FLAGS, P_WIDTH: begin
               if (phase == P_FLAGS && flag_mask(c) != 0) begin
                  flags |= flag_mask(c);
                  bump();
               end else if (phase == P_FLAGS && digit) begin
                  width_acc = add_digit('0, c);
                  width_seen = 1'b1;
                  phase = P_WIDTH;
                  bump();
               end else if (phase == P_WIDTH && digit) begin
                  width_acc = add_digit(width_acc, c);
                  bump();
               end else if (c == CH_DOT) begin
                  dot_seen = 1'b1;
                  prec_acc = '0;
                  phase = P_PREC;
                  bump();
               end else if (!take_len(c)) begin
                  close(c);
               end
            end
            P_PREC: begin
               if (digit) begin
                  prec_acc = add_digit(prec_acc, c);
                  bump();
               end else if (!take_len(c)) begin
                  close(c);
               end
            end
            P_LEN_H: begin
               if (c == CH_H_LOW) begin
                  len_seen = LM_HH;
                  phase = P_TYPE;
                  bump();
               end else begin
                  close(c);
               end
            end
            P_LEN_L: begin
               if (c == CH_L_LOW) begin
                  len_seen = LM_LL;
                  phase = P_TYPE;
                  bump();
               end else begin
                  close(c);
               end
            end
            P_TYPE: close(c);
            default: begin
               if (c == CH_PCT) begin
                  clear();
                  phase = P_FLAGS;
               end else begin
                  w = '0;
                  w.kind = KIND_LITERAL;
                  w.byte_out = c;
                  w.conv = CONV_NONE;
                  pending_words.push_back(w);
               end
            end
         endcase
      endfunction

      function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
         end
      endfunction

      function void match_word(spec_word_type got);
         spec_word_type e;
         if (pending_words.size() == 0) begin
            $error("unexpected word: kind %0d byte %0d", got.kind, got.byte_out);
            errors++;
            return;
         end
         e = pending_words.pop_front();
         cmp_field("kind", e.kind, got.kind);
         cmp_field("byte_out", e.byte_out, got.byte_out);
         cmp_field("flag_bits", e.flags, got.flags);
         cmp_field("width_value", e.width, got.width);
         cmp_field("width_given", e.width_given, got.width_given);
         cmp_field("precision_value", e.prec, got.prec);
         cmp_field("precision_given", e.prec_given, got.prec_given);
         cmp_field("length_mod", e.len, got.len);
         cmp_field("conv_type", e.conv, got.conv);
         cmp_field("spec_length", e.count, got.count);
         case (e.kind)
            KIND_LITERAL: n_lit++;
            KIND_SPEC:    n_spec++;
            KIND_INVALID: n_bad++;
            default:      n_empty++;
         endcase
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [7:0]    req_char_in;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_kind;
   logic [7:0]    rsp_byte_out;
   logic [4:0]    rsp_flag_bits;
   logic [NB-1:0] rsp_width_value;
   logic          rsp_width_given;
   logic [NB-1:0] rsp_precision_value;
   logic          rsp_precision_given;
   logic [2:0]    rsp_length_mod;
   logic [3:0]    rsp_conv_type;
   logic [CB-1:0] rsp_spec_length;

   spec_tracker_type tracker;
   bit               calm;
   int               rsp_wait = 0;
   int               cycles = 0;
   int               n_sent;

   logic [7:0] flag_chars[5] = '{CH_MINUS, CH_SHARP, CH_PLUS, CH_ZERO, CH_SPACE};
   logic [7:0] conv_chars[11] = '{CH_C, CH_S, CH_P, CH_D, CH_U, CH_O, CH_X_LOW,
                                  CH_X_UP, CH_PCT, CH_F, CH_I};

   printf_format_spec_parser_unit #(.NUMBER_BITS(NB), .COUNT_BITS(CB)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_in         (req_char_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_flag_bits       (rsp_flag_bits),
      .rsp_width_value     (rsp_width_value),
      .rsp_width_given     (rsp_width_given),
      .rsp_precision_value (rsp_precision_value),
      .rsp_precision_given (rsp_precision_given),
      .rsp_length_mod      (rsp_length_mod),
      .rsp_conv_type       (rsp_conv_type),
      .rsp_spec_length     (rsp_spec_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      spec_word_type got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.byte_out = rsp_byte_out;
         got.flags = rsp_flag_bits;
         got.width = rsp_width_value;
         got.width_given = rsp_width_given;
         got.prec = rsp_precision_value;
         got.prec_given = rsp_precision_given;
         got.len = rsp_length_mod;
         got.conv = rsp_conv_type;
         got.count = rsp_spec_length;
         tracker.match_word(got);
         rsp_wait = calm ? 0 : $urandom_range(0, 3);
      end else if (rsp_wait != 0) begin
         rsp_wait--;
      end
   end

   always @(negedge clock) begin
      rsp_stall = (rsp_wait != 0);
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_char_in = b;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      tracker.take_byte(b);
      n_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_digits(input int n);
      repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic send_spec();
      send_byte(CH_PCT);
      repeat ($urandom_range(0, 3)) send_byte(flag_chars[$urandom_range(0, 4)]);
      if ($urandom_range(0, 1) == 1) begin
         send_byte(8'(CH_ZERO + $urandom_range(1, 9)));
         send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) begin
         send_byte(CH_DOT);
         send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2));
      end
      case ($urandom_range(0, 7))
         0: send_byte(CH_H_LOW);
         1: send_text("hh");
         2: send_byte(CH_L_LOW);
         3: send_text("ll");
         4: send_byte(CH_L_UP);
         default: ;
      endcase
      if ($urandom_range(0, 5) != 0) send_byte(conv_chars[$urandom_range(0, 10)]);
      else send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      int k;
      int r;
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_in = '0;
      calm = 1'b0;
      n_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("%q");
      send_text("%-#+0 99999.99999llx");
      send_text("%5-");
      drain();

      send_byte(CH_PCT);
      repeat (300) send_byte(flag_chars[$urandom_range(0, 4)]);
      send_byte(CH_D);

      k = 0;
      while (n_sent < RANDOM_BYTES) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (k % 150 == 149) drain();
         r = $urandom_range(0, 9);
         if (r < 6) begin
            send_spec();
         end else if (r < 9) begin
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(CH_PCT);
            send_byte(8'($urandom_range(0, 255)));
         end
         k++;
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      $display("sent %0d bytes; checked %0d literal, %0d spec, %0d invalid, %0d empty words",
               n_sent, tracker.n_lit, tracker.n_spec, tracker.n_bad, tracker.n_empty);
      if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* printf_format_spec_parser_unit.f */
sv/fsp_pkg.sv
sv/fsp_parse.sv
sv/fsp_queue.sv
sv/fsp_emit.sv
sv/printf_format_spec_parser_unit.sv
test/tb_top.sv
